// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and microprogram for the bitmap block allocator.
// No dependencies; used by bitmap_block_allocator.
package bba_pkg;

    localparam int MAP_BYTES_DEF = 32;
    localparam int BYTE_W        = 8;
    localparam int BLOCK_W       = 8;
    localparam int BIT_IX_W      = 3;
    localparam int BYTE_IX_W     = BLOCK_W - BIT_IX_W;
    localparam int PTR_W         = BYTE_IX_W + 1;
    localparam int CMD_W         = 3;

    localparam logic [BYTE_W-1:0] ROW0_RESET  = 8'h01;
    localparam logic [BYTE_W-1:0] ROWN_RESET  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_FULL   = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_QUERY   = 3'd1,
        CMD_RESERVE = 3'd2,
        CMD_FREE    = 3'd3,
        CMD_FORMAT  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        UPC_FETCH    = 3'd0,
        UPC_TGT_RD   = 3'd1,
        UPC_TGT_WR   = 3'd2,
        UPC_SCAN_RD  = 3'd3,
        UPC_SCAN     = 3'd4,
        UPC_OUT      = 3'd5,
        UPC_ALLOC_WR = 3'd6,
        UPC_FMT      = 3'd7
    } upc_t;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_TGT  = 2'd1,
        RD_SCAN = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_TGT   = 2'd1,
        WR_ALLOC = 2'd2
    } wr_sel_t;

    typedef enum logic [2:0] {
        COND_JUMP     = 3'd0,
        COND_DISPATCH = 3'd1,
        COND_SCAN     = 3'd2,
        COND_OUT      = 3'd3
    } cond_t;

    typedef struct packed {
        logic    ready;
        rd_sel_t rd;
        wr_sel_t wr;
        logic    fmt;
        cond_t   cond;
        upc_t    jump;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input upc_t upc);
        ctrl_word_t cw;
        cw = '{ready: 1'b0, rd: RD_NONE, wr: WR_NONE, fmt: 1'b0,
               cond: COND_JUMP, jump: UPC_FETCH};
        case (upc)
            UPC_FETCH: begin
                cw.ready = 1'b1;
                cw.cond  = COND_DISPATCH;
            end
            UPC_TGT_RD: begin
                cw.rd   = RD_TGT;
                cw.jump = UPC_TGT_WR;
            end
            UPC_TGT_WR: begin
                cw.wr   = WR_TGT;
                cw.jump = UPC_OUT;
            end
            UPC_SCAN_RD: begin
                cw.rd   = RD_SCAN;
                cw.jump = UPC_SCAN;
            end
            UPC_SCAN: begin
                cw.rd   = RD_SCAN;
                cw.cond = COND_SCAN;
                cw.jump = UPC_ALLOC_WR;
            end
            UPC_ALLOC_WR: begin
                cw.wr   = WR_ALLOC;
                cw.jump = UPC_OUT;
            end
            UPC_FMT: begin
                cw.fmt  = 1'b1;
                cw.jump = UPC_OUT;
            end
            UPC_OUT: begin
                cw.cond = COND_OUT;
                cw.jump = UPC_FETCH;
            end
            default: begin
                cw.jump = UPC_FETCH;
            end
        endcase
        return cw;
    endfunction

    function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd);
        upc_t target;
        case (cmd)
            CMD_ALLOC, CMD_QUERY:  target = UPC_SCAN_RD;
            CMD_RESERVE, CMD_FREE: target = UPC_TGT_RD;
            CMD_FORMAT:            target = UPC_FMT;
            default:               target = UPC_OUT;
        endcase
        return target;
    endfunction

    function automatic logic [BIT_IX_W-1:0] first_clear(input logic [BYTE_W-1:0] b);
        logic [BIT_IX_W-1:0] ix;
        ix = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!b[i]) begin
                ix = BIT_IX_W'(i);
            end
        end
        return ix;
    endfunction

    function automatic logic [BYTE_W-1:0] bit_mask(input logic [BIT_IX_W-1:0] ix);
        return BYTE_W'(1) << ix;
    endfunction

endpackage

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// First-fit bitmap block allocator, top level.
// Depends on bba_pkg and bba_ram.
//
// Keeps a usage bitmap of MAP_BYTES bytes (one bit per block, set = in use) in a
// RAM with one write and one registered read port, run by an eight-step
// microprogram. For allocate and query, the scan reads one map byte per cycle
// through the single read port and stops at the first byte with a clear bit.
// Each map row has a valid bit that reset and format clear at once, so the map
// is usable as soon as reset ends. A finished result sits in an output
// register, and the next command is taken while it waits for m_ready.
module bitmap_block_allocator #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bba_pkg::CMD_W-1:0]      s_command,
    input  logic [bba_pkg::BLOCK_W-1:0]    s_block_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bba_pkg::BLOCK_W-1:0]    m_result_block,
    output logic                           m_found,
    output logic                           m_prior_used
);

    localparam int ADDR_W = $clog2(MAP_BYTES > 1 ? MAP_BYTES : 2);
    localparam int BYTE_W = bba_pkg::BYTE_W;
    localparam int BIX_W  = bba_pkg::BIT_IX_W;
    localparam int PTR_W  = bba_pkg::PTR_W;

    bba_pkg::upc_t                upc_reg, upc_next;
    bba_pkg::ctrl_word_t          cw;

    logic [bba_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [bba_pkg::BLOCK_W-1:0]  id_reg, id_next;
    logic [PTR_W-1:0]             ptr_reg, ptr_next;
    logic [ADDR_W-1:0]            rrow_reg, rrow_next;
    logic                         rvalid_reg, rvalid_next;
    logic [MAP_BYTES-1:0]         row_valid_reg, row_valid_next;
    logic [bba_pkg::BLOCK_W-1:0]  blk_reg, blk_next;
    logic                         found_reg, found_next;
    logic                         prior_reg, prior_next;
    logic [BYTE_W-1:0]            byte_reg, byte_next;
    logic                         m_valid_reg, m_valid_next;
    logic [bba_pkg::BLOCK_W-1:0]  m_blk_reg, m_blk_next;
    logic                         m_found_reg, m_found_next;
    logic                         m_prior_reg, m_prior_next;

    logic                         s_accept;
    logic                         out_free;
    logic                         in_map;
    logic                         scan_avail;
    logic                         scan_hit;
    logic                         scan_last;
    logic [BYTE_W-1:0]            ram_rdata;
    logic [BYTE_W-1:0]            map_byte;
    logic [BIX_W-1:0]             hit_bit;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [BYTE_W-1:0]            ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;

    bba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control word and datapath decode
    always_comb begin
        cw         = bba_pkg::ucode(upc_reg);
        s_accept   = cw.ready && s_valid;
        out_free   = !m_valid_reg || m_ready;
        in_map     = {1'b0, id_reg[bba_pkg::BLOCK_W-1:BIX_W]} < PTR_W'(MAP_BYTES);
        scan_avail = ptr_reg < PTR_W'(MAP_BYTES);
        map_byte   = rvalid_reg ? ram_rdata :
                     (rrow_reg == '0 ? bba_pkg::ROW0_RESET : bba_pkg::ROWN_RESET);
        scan_hit   = map_byte != bba_pkg::BYTE_FULL;
        scan_last  = rrow_reg == ADDR_W'(MAP_BYTES - 1);
        hit_bit    = bba_pkg::first_clear(map_byte);
    end

    // Next step
    always_comb begin
        upc_next = upc_reg;
        case (cw.cond)
            bba_pkg::COND_JUMP: begin
                upc_next = cw.jump;
            end
            bba_pkg::COND_DISPATCH: begin
                if (s_valid) begin
                    upc_next = bba_pkg::dispatch(s_command);
                end
            end
            bba_pkg::COND_SCAN: begin
                if (scan_hit) begin
                    upc_next = cw.jump;
                end else if (scan_last) begin
                    upc_next = bba_pkg::UPC_OUT;
                end
            end
            bba_pkg::COND_OUT: begin
                if (out_free) begin
                    upc_next = cw.jump;
                end
            end
            default: begin
                upc_next = bba_pkg::UPC_FETCH;
            end
        endcase
    end

    // Datapath actions
    always_comb begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        ptr_next       = ptr_reg;
        rrow_next      = rrow_reg;
        rvalid_next    = rvalid_reg;
        row_valid_next = row_valid_reg;
        blk_next       = blk_reg;
        found_next     = found_reg;
        prior_next     = prior_reg;
        byte_next      = byte_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_blk_next     = m_blk_reg;
        m_found_next   = m_found_reg;
        m_prior_next   = m_prior_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (s_accept) begin
            cmd_next   = s_command;
            id_next    = s_block_id;
            ptr_next   = '0;
            blk_next   = '0;
            found_next = 1'b0;
            prior_next = 1'b0;
        end

        case (cw.rd)
            bba_pkg::RD_TGT: begin
                ram_re    = in_map;
                ram_raddr = id_reg[BIX_W +: ADDR_W];
            end
            bba_pkg::RD_SCAN: begin
                ram_re    = scan_avail;
                ram_raddr = ptr_reg[ADDR_W-1:0];
                if (scan_avail) begin
                    ptr_next = PTR_W'(ptr_reg + 1'b1);
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
        if (ram_re) begin
            rrow_next   = ram_raddr;
            rvalid_next = row_valid_reg[ram_raddr];
        end

        if (cw.cond == bba_pkg::COND_SCAN && scan_hit) begin
            blk_next   = {bba_pkg::BYTE_IX_W'(rrow_reg), hit_bit};
            found_next = 1'b1;
            byte_next  = map_byte;
        end

        case (cw.wr)
            bba_pkg::WR_TGT: begin
                ram_we    = in_map;
                ram_waddr = id_reg[BIX_W +: ADDR_W];
                if (cmd_reg == bba_pkg::CMD_FREE) begin
                    ram_wdata = map_byte & ~bba_pkg::bit_mask(id_reg[BIX_W-1:0]);
                end else begin
                    ram_wdata = map_byte | bba_pkg::bit_mask(id_reg[BIX_W-1:0]);
                end
                prior_next = in_map && map_byte[id_reg[BIX_W-1:0]];
            end
            bba_pkg::WR_ALLOC: begin
                ram_we    = cmd_reg == bba_pkg::CMD_ALLOC;
                ram_waddr = blk_reg[BIX_W +: ADDR_W];
                ram_wdata = byte_reg | bba_pkg::bit_mask(blk_reg[BIX_W-1:0]);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        if (ram_we) begin
            row_valid_next[ram_waddr] = 1'b1;
        end

        if (cw.fmt) begin
            row_valid_next = '0;
        end

        if (cw.cond == bba_pkg::COND_OUT && out_free) begin
            m_valid_next = 1'b1;
            m_blk_next   = blk_reg;
            m_found_next = found_reg;
            m_prior_next = prior_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= bba_pkg::UPC_FETCH;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            upc_reg       <= upc_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        ptr_reg     <= ptr_next;
        rrow_reg    <= rrow_next;
        rvalid_reg  <= rvalid_next;
        blk_reg     <= blk_next;
        found_reg   <= found_next;
        prior_reg   <= prior_next;
        byte_reg    <= byte_next;
        m_blk_reg   <= m_blk_next;
        m_found_reg <= m_found_next;
        m_prior_reg <= m_prior_next;
    end

    assign s_ready        = cw.ready;
    assign m_valid        = m_valid_reg;
    assign m_result_block = m_blk_reg;
    assign m_found        = m_found_reg;
    assign m_prior_used   = m_prior_reg;

endmodule
